FILE: hdl/ceq_pkg.sv
// Shared types and constants for the coalescing event queue.
// No dependencies; imported by coalescing_event_queue and ceq_ctrl.
`default_nettype none
package ceq_pkg;

  localparam int DEF_QUEUE_DEPTH   = 16;
  localparam int DEF_PAYLOAD_BYTES = 8;
  localparam int CODE_W            = 8;
  localparam int FLEN_W            = 4;

  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_COALESCED = 3'd1,
    ST_IGNORED   = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_FULL      = 3'd4,
    ST_FETCHED   = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

  typedef struct packed {
    logic is_fetch;
    logic ignored;
    logic too_long;
  } cmd_t;

endpackage
`default_nettype wire

FILE: hdl/coalescing_event_queue.sv
// Coalescing event queue top level: enable register, item decode, payload mask.
// Depends on ceq_pkg, ceq_ctrl and ceq_ram.
//
//   channel  handshake        payload
//   -------  ---------------  --------------------------------------------------
//   cfg      cfg_we           cfg_wdata (events_enable)
//   item in  start && !busy   action, event_code, payload, payload_len
//   result   done (1 cycle)   status, fetched_code, fetched_payload, fetched_len,
//                             raise_irq, current_event
//
// Rejected posts, stores into an empty queue and fetches on an empty queue finish
// straight from idle; a fetch goes through S_FETCH (one RAM read). Other posts scan the
// waiting entries through the RAM read port, one entry a cycle.
// Synchronous reset empties the queue and clears current_event and the enable.
// Results cannot be stalled; busy stays high until the result is shown.
`default_nettype none
module coalescing_event_queue
  import ceq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
  parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES,
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int LW = $clog2(PAYLOAD_BYTES + 1),
  localparam int PW = 8 * PAYLOAD_BYTES,
  localparam int EW = CODE_W + LW + PW
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              action,
  input  wire logic [CODE_W-1:0] event_code,
  input  wire logic [PW-1:0]     payload,
  input  wire logic [7:0]        payload_len,
  output logic                   done,
  output status_t                status,
  output logic      [CODE_W-1:0] fetched_code,
  output logic      [PW-1:0]     fetched_payload,
  output logic      [FLEN_W-1:0] fetched_len,
  output logic                   raise_irq,
  output logic      [CODE_W-1:0] current_event
);

  logic          events_enable;
  cmd_t          cmd;
  logic [PW-1:0] data_masked;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      events_enable <= 1'b0;
    end else if (cfg_we) begin
      events_enable <= cfg_wdata;
    end
  end

  assign cmd.is_fetch = action;
  assign cmd.ignored  = !events_enable || (event_code == '0);
  assign cmd.too_long = (payload_len > 8'(PAYLOAD_BYTES));

  always_comb begin
    for (int b = 0; b < PAYLOAD_BYTES; b++) begin
      data_masked[8*b +: 8] = (payload_len > 8'(b)) ? payload[8*b +: 8] : 8'h00;
    end
  end

  ceq_ctrl #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .cmd            (cmd),
    .code_in        (event_code),
    .len_in         (payload_len[LW-1:0]),
    .data_in        (data_masked),
    .busy           (busy),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .done           (done),
    .status         (status),
    .fetched_code   (fetched_code),
    .fetched_payload(fetched_payload),
    .fetched_len    (fetched_len),
    .raise_irq      (raise_irq),
    .current_event  (current_event)
  );

  ceq_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

`ifndef SYNTHESIS
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted item neither finished nor in progress");

  a_fetch_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FETCHED) |-> (fetched_code != '0 && current_event == fetched_code))
    else $error("fetched entry has zero code or was not latched");

  a_post_no_data: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_FETCHED) |-> (fetched_code == '0 && fetched_len == '0))
    else $error("non-fetch result carries fetched data");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result strobe without an item");
`endif

endmodule
`default_nettype wire

FILE: hdl/ceq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module ceq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/ceq_ctrl.sv
// Queue controller: head/tail/count, coalescing scan over the entry RAM, pop.
// Depends on ceq_pkg; drives the ports of one ceq_ram instance.
`default_nettype none
module ceq_ctrl
  import ceq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
  parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES,
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CW = $clog2(QUEUE_DEPTH + 1),
  localparam int LW = $clog2(PAYLOAD_BYTES + 1),
  localparam int PW = 8 * PAYLOAD_BYTES,
  localparam int EW = CODE_W + LW + PW
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire cmd_t              cmd,
  input  wire logic [CODE_W-1:0] code_in,
  input  wire logic [LW-1:0]     len_in,
  input  wire logic [PW-1:0]     data_in,
  output logic                   busy,
  output logic                   ram_we,
  output logic      [AW-1:0]     ram_waddr,
  output logic      [EW-1:0]     ram_wdata,
  output logic      [AW-1:0]     ram_raddr,
  input  wire logic [EW-1:0]     ram_rdata,
  output logic                   done,
  output status_t                status,
  output logic      [CODE_W-1:0] fetched_code,
  output logic      [PW-1:0]     fetched_payload,
  output logic      [FLEN_W-1:0] fetched_len,
  output logic                   raise_irq,
  output logic      [CODE_W-1:0] current_event
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH
  } state_t;

  state_t            state;
  logic [AW-1:0]     head;
  logic [AW-1:0]     tail;
  logic [CW-1:0]     count;
  logic [AW-1:0]     scan_ptr;
  logic [CW-1:0]     scan_idx;
  logic [CODE_W-1:0] code_q;
  logic [LW-1:0]     len_q;
  logic [PW-1:0]     data_q;

  logic [CODE_W-1:0] rd_code;
  logic [LW-1:0]     rd_len;
  logic [PW-1:0]     rd_data;
  logic              hit;
  logic              last;
  logic              full;

  function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign rd_code = ram_rdata[EW-1 -: CODE_W];
  assign rd_len  = ram_rdata[PW +: LW];
  assign rd_data = ram_rdata[PW-1:0];
  assign hit     = (rd_code == code_q);
  assign last    = (scan_idx == count - CW'(1));
  assign full    = (count == CW'(QUEUE_DEPTH));
  assign busy    = (state != S_IDLE);

  assign ram_raddr = (state == S_IDLE) ? head : next_ptr(scan_ptr);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail;
    ram_wdata = {code_q, len_q, data_q};
    unique case (state)
      S_IDLE: begin
        if (start && !cmd.is_fetch && !cmd.ignored && !cmd.too_long && count == '0) begin
          ram_we    = 1'b1;
          ram_wdata = {code_in, len_in, data_in};
        end
      end
      S_SCAN: begin
        if (hit) begin
          ram_we    = 1'b1;
          ram_waddr = scan_ptr;
        end else if (last && !full) begin
          ram_we = 1'b1;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head          <= '0;
      tail          <= '0;
      count         <= '0;
      done          <= 1'b0;
      current_event <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            code_q          <= code_in;
            len_q           <= len_in;
            data_q          <= data_in;
            fetched_code    <= '0;
            fetched_payload <= '0;
            fetched_len     <= '0;
            raise_irq       <= 1'b0;
            if (cmd.is_fetch) begin
              if (count == '0) begin
                done   <= 1'b1;
                status <= ST_EMPTY;
              end else begin
                state <= S_FETCH;
              end
            end else if (cmd.ignored) begin
              done   <= 1'b1;
              status <= ST_IGNORED;
            end else if (cmd.too_long) begin
              done   <= 1'b1;
              status <= ST_TOO_LONG;
            end else if (count == '0) begin
              tail      <= next_ptr(tail);
              count     <= count + CW'(1);
              done      <= 1'b1;
              status    <= ST_STORED;
              raise_irq <= 1'b1;
            end else begin
              scan_ptr <= head;
              scan_idx <= '0;
              state    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            done   <= 1'b1;
            status <= ST_COALESCED;
            state  <= S_IDLE;
          end else if (last) begin
            done  <= 1'b1;
            state <= S_IDLE;
            if (full) begin
              status <= ST_FULL;
            end else begin
              tail   <= next_ptr(tail);
              count  <= count + CW'(1);
              status <= ST_STORED;
            end
          end else begin
            scan_ptr <= next_ptr(scan_ptr);
            scan_idx <= scan_idx + CW'(1);
          end
        end
        S_FETCH: begin
          done            <= 1'b1;
          status          <= ST_FETCHED;
          fetched_code    <= rd_code;
          fetched_payload <= rd_data;
          fetched_len     <= FLEN_W'(rd_len);
          raise_irq       <= (count != CW'(1));
          current_event   <= rd_code;
          head            <= next_ptr(head);
          count           <= count - CW'(1);
          state           <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: verif/tb_coalescing_event_queue.sv
// Self-checking testbench for coalescing_event_queue: directed posts and fetches, then
// random phases with sender gaps, each result checked against an in-order queue predictor.
// Depends on ceq_pkg and the RTL of the block; reads no files.
module tb_coalescing_event_queue;
  import ceq_pkg::*;

  localparam int DEPTH = DEF_QUEUE_DEPTH;
  localparam int PBYTES = DEF_PAYLOAD_BYTES;
  localparam logic ACT_POST = 1'b0;
  localparam logic ACT_FETCH = 1'b1;
  localparam int SETTLE_CYCLES = DEPTH + 4;
  localparam int PHASE_ITEMS = 175;
  localparam int MAX_REPORTS = 50;

  typedef struct {
    status_t status;
    logic [7:0] code;
    logic [63:0] data;
    logic [3:0] len;
    logic irq;
    logic [7:0] cur;
  } outcome_t;

  class event_queue_tracker;
    bit enable;
    logic [7:0] codes[DEPTH];
    logic [63:0] datas[DEPTH];
    logic [3:0] lens[DEPTH];
    int count;
    logic [7:0] last_code = 8'd0;
    int errors;
    outcome_t outcome_q[$];

    function void note_item(logic act, logic [7:0] code, logic [63:0] data, logic [7:0] len);
      outcome_t o;
      int hit;
      logic [63:0] kept;
      o.status = ST_IGNORED;
      o.code = 8'd0;
      o.data = 64'd0;
      o.len = 4'd0;
      o.irq = 1'b0;
      hit = -1;
      if (act == ACT_POST) begin
        if (!enable || code == 8'd0) begin
          o.status = ST_IGNORED;
        end else if (len > PBYTES) begin
          o.status = ST_TOO_LONG;
        end else begin
          kept = (len >= 8) ? data : data & ((64'd1 << (8 * len)) - 64'd1);
          for (int i = 0; i < count; i++)
            if (hit < 0 && codes[i] == code) hit = i;
          if (hit >= 0) begin
            datas[hit] = kept;
            lens[hit] = len[3:0];
            o.status = ST_COALESCED;
          end else if (count >= DEPTH) begin
            o.status = ST_FULL;
          end else begin
            codes[count] = code;
            datas[count] = kept;
            lens[count] = len[3:0];
            count++;
            o.status = ST_STORED;
            o.irq = (count == 1);
          end
        end
      end else if (count == 0) begin
        o.status = ST_EMPTY;
      end else begin
        o.code = codes[0];
        o.data = datas[0];
        o.len = lens[0];
        last_code = codes[0];
        for (int i = 1; i < count; i++) begin
          codes[i-1] = codes[i];
          datas[i-1] = datas[i];
          lens[i-1] = lens[i];
        end
        count--;
        o.status = ST_FETCHED;
        o.irq = (count > 0);
      end
      o.cur = last_code;
      outcome_q.insert(outcome_q.size(), o);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        if (errors < MAX_REPORTS)
          $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(status_t status, logic [7:0] code, logic [63:0] data,
                               logic [3:0] len, logic irq, logic [7:0] cur);
      outcome_t o;
      if (outcome_q.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: unexpected result: expected none, actual status %0d code %0h",
                   $time, status, code);
        errors++;
        return;
      end
      o = outcome_q.pop_front();
      compare("status", o.status, status);
      compare("fetched_code", o.code, code);
      compare("fetched_payload", o.data, data);
      compare("fetched_len", o.len, len);
      compare("raise_irq", o.irq, irq);
      compare("current_event", o.cur, cur);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  logic start;
  logic busy;
  logic action;
  logic [7:0] event_code;
  logic [63:0] payload;
  logic [7:0] payload_len;
  logic done;
  status_t status;
  logic [7:0] fetched_code;
  logic [63:0] fetched_payload;
  logic [3:0] fetched_len;
  logic raise_irq;
  logic [7:0] current_event;

  event_queue_tracker tracker;

  coalescing_event_queue u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .start(start),
    .busy(busy),
    .action(action),
    .event_code(event_code),
    .payload(payload),
    .payload_len(payload_len),
    .done(done),
    .status(status),
    .fetched_code(fetched_code),
    .fetched_payload(fetched_payload),
    .fetched_len(fetched_len),
    .raise_irq(raise_irq),
    .current_event(current_event)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_coalescing_event_queue NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done)
      tracker.check_result(status, fetched_code, fetched_payload, fetched_len, raise_irq,
                           current_event);
  end

  task automatic send_item(logic act, logic [7:0] code, logic [63:0] data, logic [7:0] len);
    @(negedge clk);
    start <= 1'b1;
    action <= act;
    event_code <= code;
    payload <= data;
    payload_len <= len;
    do @(posedge clk); while (busy);
    tracker.note_item(act, code, data, len);
  endtask

  task automatic pause(int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.outcome_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_events_enable(logic value);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    tracker.enable = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    bit draining;
    int pick;
    int pct;
    logic act;
    logic [7:0] code;
    logic [7:0] len;
    logic [63:0] data;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    start = 1'b0;
    action = ACT_POST;
    event_code = 8'd0;
    payload = 64'd0;
    payload_len = 8'd0;
    draining = 1'b0;
    tracker = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_events_enable(1'b0);
    // posts drop while disabled, length unchecked
    send_item(ACT_POST, 8'h80, '1, 8'hFF);
    send_item(ACT_FETCH, 8'h00, 64'd0, 8'h00);
    set_events_enable(1'b1);
    send_item(ACT_POST, 8'h00, '1, 8'hFF);
    send_item(ACT_POST, 8'h07, '1, 8'd9);
    send_item(ACT_POST, 8'h01, '1, 8'd0);
    send_item(ACT_POST, 8'hFF, '1, 8'd8);
    send_item(ACT_POST, 8'h01, 64'h0123_4567_89AB_CDEF, 8'd3);
    for (int c = 2; c < DEPTH; c++)
      send_item(ACT_POST, c[7:0], {$urandom, $urandom}, 8'($urandom_range(0, 8)));
    // queue full: a new code is refused, a waiting code still coalesces
    send_item(ACT_POST, 8'h10, {$urandom, $urandom}, 8'd4);
    send_item(ACT_POST, 8'hFF, {$urandom, $urandom}, 8'd5);
    send_item(ACT_FETCH, 8'hFF, '1, 8'hFF);

    for (int phase = 0; phase < 6; phase++) begin
      set_events_enable(phase != 2);
      case (phase % 3)
        0: pct = 0;
        1: pct = 67;
        default: pct = 6;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < pct)
          pause(($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3));
        if (tracker.count == 0)
          draining = 1'b0;
        else if (tracker.count == DEPTH && $urandom_range(0, 3) == 0)
          draining = 1'b1;
        act = ($urandom_range(0, 99) < (draining ? 70 : 20)) ? ACT_FETCH : ACT_POST;
        pick = $urandom_range(0, 99);
        if (pick < 10) code = 8'd0;
        else if (pick < 25) code = 8'($urandom_range(0, 255));
        else code = 8'($urandom_range(1, 24));
        pick = $urandom_range(0, 99);
        if (pick < 10) data = '1;
        else if (pick < 15) data = 64'd0;
        else data = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 75) len = 8'($urandom_range(0, 8));
        else if (pick < 85) len = 8'($urandom_range(9, 20));
        else len = 8'($urandom_range(0, 255));
        send_item(act, code, data, len);
      end
    end

    settle();
    if (tracker.errors == 0 && tracker.outcome_q.size() == 0)
      $display("tb_coalescing_event_queue OK");
    else
      $display("tb_coalescing_event_queue NOT OK");
    $finish;
  end

endmodule
